### rtl/tlru_pkg.sv
// Shared constants for the fully associative TLB: operation codes, modes, defaults.
package tlru_pkg;

  localparam int ENTRIES_DEFAULT  = 4;
  localparam int VPN_BITS_DEFAULT = 16;
  localparam int PPN_BITS_DEFAULT = 16;

  // Width of the shared fill/use stamp counter.
  localparam int STAMP_BITS = 32;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_REFILL = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Replacement rule when every entry is valid.
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // Register index of replace_mode on the configuration port.
  localparam logic REG_REPLACE_MODE = 1'b0;

endpackage

### rtl/tlru_cell.sv
// One TLB entry cell: holds an entry and updates the probe passing down the chain.
module tlru_cell #(
  parameter  int VPN_BITS = tlru_pkg::VPN_BITS_DEFAULT,
  parameter  int PPN_BITS = tlru_pkg::PPN_BITS_DEFAULT,
  parameter  int IDX_W    = 2,
  parameter  int CELL_IDX = 0,
  localparam int PROBE_W  = 5 + VPN_BITS + PPN_BITS + 3 * IDX_W + tlru_pkg::STAMP_BITS,
  localparam int CMD_W    = 4 + IDX_W + VPN_BITS + PPN_BITS + tlru_pkg::STAMP_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic mode,
  input  logic [PROBE_W-1:0] probe_in,
  output logic [PROBE_W-1:0] probe_out,
  input  logic [CMD_W-1:0]   cmd_in
);

  typedef struct packed {
    logic                            vld;
    logic [VPN_BITS-1:0]             vpn;
    logic                            hit;
    logic [IDX_W-1:0]                hit_idx;
    logic [PPN_BITS-1:0]             ppn;
    logic                            ro;
    logic                            inv_found;
    logic [IDX_W-1:0]                inv_idx;
    logic                            best_set;
    logic [tlru_pkg::STAMP_BITS-1:0] best_stamp;
    logic [IDX_W-1:0]                best_idx;
  } probe_t;

  typedef struct packed {
    logic                            fill;
    logic                            touch;
    logic                            clear;
    logic [IDX_W-1:0]                slot;
    logic [VPN_BITS-1:0]             vpn;
    logic [PPN_BITS-1:0]             ppn;
    logic                            ro;
    logic [tlru_pkg::STAMP_BITS-1:0] stamp;
  } cmd_t;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                            valid;
  logic [VPN_BITS-1:0]             vpn_q;
  logic [PPN_BITS-1:0]             ppn_q;
  logic                            ro_q;
  logic [tlru_pkg::STAMP_BITS-1:0] fill_q;
  logic [tlru_pkg::STAMP_BITS-1:0] use_q;

  probe_t pin;
  probe_t probe_next;
  probe_t pout;
  cmd_t   cmd;
  logic   sel;

  assign pin       = probe_t'(probe_in);
  assign cmd       = cmd_t'(cmd_in);
  assign probe_out = pout;
  assign sel       = (cmd.slot == MY_IDX);

  always_comb begin
    logic [tlru_pkg::STAMP_BITS-1:0] stamp;
    stamp      = (mode == tlru_pkg::MODE_LRU) ? use_q : fill_q;
    probe_next = pin;
    // The first matching valid entry along the chain wins.
    if (valid && (vpn_q == pin.vpn) && !pin.hit) begin
      probe_next.hit     = 1'b1;
      probe_next.hit_idx = MY_IDX;
      probe_next.ppn     = ppn_q;
      probe_next.ro      = ro_q;
    end
    if (!valid && !pin.inv_found) begin
      probe_next.inv_found = 1'b1;
      probe_next.inv_idx   = MY_IDX;
    end
    // Strictly smaller replaces, so ties stay with the lower index.
    if (valid && (!pin.best_set || (stamp < pin.best_stamp))) begin
      probe_next.best_set   = 1'b1;
      probe_next.best_stamp = stamp;
      probe_next.best_idx   = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout.vld <= 1'b0;
      valid    <= 1'b0;
    end else begin
      pout.vld <= pin.vld;
      if (cmd.clear) begin
        valid <= 1'b0;
      end else if (cmd.fill && sel) begin
        valid <= 1'b1;
      end
    end
    pout.vpn        <= probe_next.vpn;
    pout.hit        <= probe_next.hit;
    pout.hit_idx    <= probe_next.hit_idx;
    pout.ppn        <= probe_next.ppn;
    pout.ro         <= probe_next.ro;
    pout.inv_found  <= probe_next.inv_found;
    pout.inv_idx    <= probe_next.inv_idx;
    pout.best_set   <= probe_next.best_set;
    pout.best_stamp <= probe_next.best_stamp;
    pout.best_idx   <= probe_next.best_idx;
    if (cmd.fill && sel) begin
      vpn_q  <= cmd.vpn;
      ppn_q  <= cmd.ppn;
      ro_q   <= cmd.ro;
      fill_q <= cmd.stamp;
      use_q  <= cmd.stamp;
    end else if (cmd.touch && sel) begin
      use_q <= cmd.stamp;
    end
  end

endmodule

### rtl/tlb_lookup_refill_fifo_lru.sv
// Top level of the fully associative TLB built as a chain of entry cells.
//
// Usage: an item on the slave stream carries the operation on s_axis_tuser
// (lookup, refill or clear) and the virtual page, fill physical page and
// fill read-only flag on s_axis_tdata. Every item yields exactly one result
// item on the master stream: hit flag, physical page, read-only flag, slot.
// The replacement rule (FIFO or LRU) is set through the APB-style port. The
// user must write it only while the block is idle; the block does not check.
//
// One item is in flight at a time. A probe enters the first cell at the
// accept edge and moves one cell per cycle to the chain end, where the
// result is latched into res; the commit then updates the entry and loads
// the output register, and the block returns to idle to take the next
// item. The time an item takes is set by the length of the cell chain.
//
// Reset (synchronous, active high) clears all valid bits, the stamp counter,
// the mode register and the output valid. If the receiver stalls, the result
// holds in the output register; one more item is still taken and scanned,
// and it waits at the chain end until the output register frees up.
module tlb_lookup_refill_fifo_lru #(
  parameter  int ENTRIES  = tlru_pkg::ENTRIES_DEFAULT,
  parameter  int VPN_BITS = tlru_pkg::VPN_BITS_DEFAULT,
  parameter  int PPN_BITS = tlru_pkg::PPN_BITS_DEFAULT,
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int IN_DW    = ((VPN_BITS + PPN_BITS + 1 + 7) / 8) * 8,
  localparam int OUT_DW   = ((PPN_BITS + IDX_W + 2 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // Fields from bit 0 up: virtual_page, fill_physical_page, fill_read_only.
  input  logic [IN_DW-1:0]  s_axis_tdata,
  // Fields from bit 0 up: operation.
  input  logic [1:0]        s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // Fields from bit 0 up: hit, physical_page, read_only, slot.
  output logic [OUT_DW-1:0] m_axis_tdata,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef struct packed {
    logic                            vld;
    logic [VPN_BITS-1:0]             vpn;
    logic                            hit;
    logic [IDX_W-1:0]                hit_idx;
    logic [PPN_BITS-1:0]             ppn;
    logic                            ro;
    logic                            inv_found;
    logic [IDX_W-1:0]                inv_idx;
    logic                            best_set;
    logic [tlru_pkg::STAMP_BITS-1:0] best_stamp;
    logic [IDX_W-1:0]                best_idx;
  } probe_t;

  typedef struct packed {
    logic                            fill;
    logic                            touch;
    logic                            clear;
    logic [IDX_W-1:0]                slot;
    logic [VPN_BITS-1:0]             vpn;
    logic [PPN_BITS-1:0]             ppn;
    logic                            ro;
    logic [tlru_pkg::STAMP_BITS-1:0] stamp;
  } cmd_t;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state;
  logic                            mode;
  logic [tlru_pkg::STAMP_BITS-1:0] stamp_counter;
  logic [1:0]                      op_q;
  logic [VPN_BITS-1:0]             vpn_q;
  logic [PPN_BITS-1:0]             fill_ppn_q;
  logic                            fill_ro_q;
  probe_t                          res;

  logic                            out_hit;
  logic [PPN_BITS-1:0]             out_ppn;
  logic                            out_ro;
  logic [IDX_W-1:0]                out_slot;

  probe_t                          chain [ENTRIES+1];
  cmd_t                            cmd;
  logic                            accept;
  logic                            commit;
  logic [IDX_W-1:0]                victim;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);
  // An invalid slot is preferred; otherwise the oldest stamp under the mode.
  assign victim        = res.inv_found ? res.inv_idx : res.best_idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tlru_pkg::REG_REPLACE_MODE) ? {31'b0, mode} : 32'b0;

  assign m_axis_tdata = OUT_DW'({out_slot, out_ro, out_ppn, out_hit});

  // The probe injected into the first cell starts with nothing found.
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = accept;
    chain[0].vpn = s_axis_tdata[VPN_BITS-1:0];
  end

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      tlru_cell #(
        .VPN_BITS (VPN_BITS),
        .PPN_BITS (PPN_BITS),
        .IDX_W    (IDX_W),
        .CELL_IDX (gi)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .mode      (mode),
        .probe_in  (chain[gi]),
        .probe_out (chain[gi+1]),
        .cmd_in    (cmd)
      );
    end
  endgenerate

  // Entry update broadcast to all cells in the commit cycle.
  always_comb begin
    cmd       = '0;
    cmd.vpn   = vpn_q;
    cmd.ppn   = fill_ppn_q;
    cmd.ro    = fill_ro_q;
    cmd.stamp = stamp_counter;
    if (commit) begin
      unique case (op_q)
        tlru_pkg::OP_LOOKUP: begin
          cmd.touch = res.hit;
          cmd.slot  = res.hit_idx;
        end
        tlru_pkg::OP_REFILL: begin
          cmd.fill = 1'b1;
          cmd.slot = victim;
        end
        tlru_pkg::OP_CLEAR: begin
          cmd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mode          <= tlru_pkg::MODE_FIFO;
      stamp_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready &&
          (paddr[2] == tlru_pkg::REG_REPLACE_MODE)) begin
        mode <= pwdata[0];
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (chain[ENTRIES].vld) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (commit && ((cmd.touch) || (cmd.fill))) begin
        stamp_counter <= stamp_counter + 1'b1;
      end
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= s_axis_tuser;
      vpn_q      <= s_axis_tdata[VPN_BITS-1:0];
      fill_ppn_q <= s_axis_tdata[VPN_BITS+PPN_BITS-1:VPN_BITS];
      fill_ro_q  <= s_axis_tdata[VPN_BITS+PPN_BITS];
    end
    if ((state == ST_SCAN) && chain[ENTRIES].vld) begin
      res <= chain[ENTRIES];
    end
    if (commit) begin
      out_hit  <= 1'b0;
      out_ppn  <= '0;
      out_ro   <= 1'b0;
      out_slot <= '0;
      if ((op_q == tlru_pkg::OP_LOOKUP) && res.hit) begin
        out_hit  <= 1'b1;
        out_ppn  <= res.ppn;
        out_ro   <= res.ro;
        out_slot <= res.hit_idx;
      end else if (op_q == tlru_pkg::OP_REFILL) begin
        out_slot <= victim;
      end
    end
  end

endmodule

### rtl/tlru_checker.sv
// Port-level assertions for the TLB and the bind that attaches them.
module tlru_checker #(
  parameter  int ENTRIES  = tlru_pkg::ENTRIES_DEFAULT,
  parameter  int VPN_BITS = tlru_pkg::VPN_BITS_DEFAULT,
  parameter  int PPN_BITS = tlru_pkg::PPN_BITS_DEFAULT,
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int OUT_DW   = ((PPN_BITS + IDX_W + 2 + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // No result is pending right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // Only one item is worked on at a time.
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // A result without a hit carries no translation.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[PPN_BITS+1:1] == '0)
    else $error("translation fields set without a hit");

endmodule

bind tlb_lookup_refill_fifo_lru tlru_checker #(
  .ENTRIES  (ENTRIES),
  .VPN_BITS (VPN_BITS),
  .PPN_BITS (PPN_BITS)
) u_tlru_checker (.*);
